>>> design/ujt_pkg.sv
// ----------------------------------------------------------------------------
// ujt_pkg
// Shared widths, register codes and the CORDIC arctangent table for the
// universal joint transform.
// ----------------------------------------------------------------------------
package ujt_pkg;

   localparam int ANGLE_WIDTH  = 16;
   localparam int ENTRY_WIDTH  = 16;
   localparam int FRAC_BITS    = ENTRY_WIDTH - 2;
   localparam int CORDIC_STEPS = 30;

   localparam int XW = 34;
   localparam int ZW = 34;
   localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

   localparam int CS_SHIFT = 30 - FRAC_BITS;
   localparam int CS_W     = FRAC_BITS + 3;
   localparam int J_W      = CS_W + 1;
   localparam int P_W      = 2 * CS_W;

   localparam int ROT_W    = 16;
   localparam int ROT_FRAC = 14;
   localparam int ROW_W    = 3 * ROT_W;
   localparam int POS_W    = 32;
   localparam int MP_W     = ROT_W + J_W;
   localparam int ACC_W    = MP_W + 2;

   localparam logic signed [XW-1:0]    CS_RND  = XW'((64'd1 << CS_SHIFT) >> 1);
   localparam logic signed [P_W-1:0]   J_RND   = P_W'((64'd1 << FRAC_BITS) >> 1);
   localparam logic signed [ACC_W-1:0] M_RND   = ACC_W'((64'd1 << ROT_FRAC) >> 1);
   localparam logic signed [ACC_W-1:0] M_HI    = ACC_W'((64'd1 << (ENTRY_WIDTH - 1)) - 1);
   localparam logic signed [ACC_W-1:0] M_LO    = -M_HI - ACC_W'(1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POS_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POS_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_POS_Z    = 3'd5;

   localparam logic [ROW_W-1:0] ROW0_RESET = 48'd16384;
   localparam logic [ROW_W-1:0] ROW1_RESET = 48'd1073741824;
   localparam logic [ROW_W-1:0] ROW2_RESET = 48'd70368744177664;

   typedef logic signed [CS_W-1:0]        cs_type;
   typedef logic signed [J_W-1:0]         j_type;
   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;

   localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

endpackage

>>> design/ujt_cordic.sv
// ----------------------------------------------------------------------------
// ujt_cordic
// Two-lane pipelined CORDIC: quadrant fold, one rotation per stage, then
// rounding to the sine/cosine format and the fold sign applied.
// ----------------------------------------------------------------------------
module ujt_cordic
   import ujt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  logic [ANGLE_WIDTH-1:0] angle [2],
   output logic                   out_valid,
   output cs_type                 cos_out [2],
   output cs_type                 sin_out [2]
);

   logic                 valid_ff [0:CORDIC_STEPS];
   logic signed [XW-1:0] x_ff     [2][0:CORDIC_STEPS];
   logic signed [XW-1:0] y_ff     [2][0:CORDIC_STEPS];
   logic signed [ZW-1:0] z_ff     [2][0:CORDIC_STEPS];
   logic                 flip_ff  [2][0:CORDIC_STEPS];
   logic                 out_valid_ff;
   cs_type               cos_ff [2];
   cs_type               sin_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0]  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff[0]  <= in_valid;
         out_valid_ff <= valid_ff[CORDIC_STEPS];
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [31:0] t_in;
      logic        flip_in;
      logic signed [XW-1:0] xr_in;
      logic signed [XW-1:0] yr_in;
      cs_type      xc_in;
      cs_type      yc_in;

      // quadrant fold: second and third quarter turn rotated by half a turn
      assign t_in    = 32'(angle[l]) << (32 - ANGLE_WIDTH);
      assign flip_in = t_in[31] ^ t_in[30];

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[l][0]    <= CORDIC_GAIN;
            y_ff[l][0]    <= '0;
            z_ff[l][0]    <= ZW'(signed'({t_in[31] ^ flip_in, t_in[30:0]}));
            flip_ff[l][0] <= flip_in;
         end
      end

      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
         always_ff @(posedge clock) begin
            if (enable) begin
               flip_ff[l][i+1] <= flip_ff[l][i];
               if (!z_ff[l][i][ZW-1]) begin
                  x_ff[l][i+1] <= x_ff[l][i] - (y_ff[l][i] >>> i);
                  y_ff[l][i+1] <= y_ff[l][i] + (x_ff[l][i] >>> i);
                  z_ff[l][i+1] <= z_ff[l][i] - signed'(ZW'(ATAN_TURN[i]));
               end else begin
                  x_ff[l][i+1] <= x_ff[l][i] + (y_ff[l][i] >>> i);
                  y_ff[l][i+1] <= y_ff[l][i] - (x_ff[l][i] >>> i);
                  z_ff[l][i+1] <= z_ff[l][i] + signed'(ZW'(ATAN_TURN[i]));
               end
            end
         end
      end

      assign xr_in = (x_ff[l][CORDIC_STEPS] + CS_RND) >>> CS_SHIFT;
      assign yr_in = (y_ff[l][CORDIC_STEPS] + CS_RND) >>> CS_SHIFT;
      assign xc_in = flip_ff[l][CORDIC_STEPS] ? -CS_W'(xr_in) : CS_W'(xr_in);
      assign yc_in = flip_ff[l][CORDIC_STEPS] ? -CS_W'(yr_in) : CS_W'(yr_in);

      always_ff @(posedge clock) begin
         if (enable) begin
            cos_ff[l] <= xc_in;
            sin_ff[l] <= yc_in;
         end
      end

      assign cos_out[l] = cos_ff[l];
      assign sin_out[l] = sin_ff[l];
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end
   end

   assign out_valid = out_valid_ff;

endmodule

>>> design/ujt_joint.sv
// ----------------------------------------------------------------------------
// ujt_joint
// Builds the joint rotation Rx(q0)*Ry(q1) from the two sine/cosine pairs:
// one stage of products, one stage of rounding and sign.
// ----------------------------------------------------------------------------
module ujt_joint
   import ujt_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   enable,
   input  logic   in_valid,
   input  cs_type cos_in [2],
   input  cs_type sin_in [2],
   output logic   out_valid,
   output j_type  j_out [3][3]
);

   logic                  valid_a_ff;
   logic                  valid_b_ff;
   logic signed [P_W-1:0] ss_ff, sc_ff, cs_ff, cc_ff;
   cs_type                c0_ff, s0_ff, c1_ff, s1_ff;
   logic signed [P_W-1:0] ss_in, sc_in, cs_in, cc_in;
   j_type                 j_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ss_ff <= P_W'(sin_in[0]) * P_W'(sin_in[1]);
         sc_ff <= P_W'(sin_in[0]) * P_W'(cos_in[1]);
         cs_ff <= P_W'(cos_in[0]) * P_W'(sin_in[1]);
         cc_ff <= P_W'(cos_in[0]) * P_W'(cos_in[1]);
         c0_ff <= cos_in[0];
         s0_ff <= sin_in[0];
         c1_ff <= cos_in[1];
         s1_ff <= sin_in[1];
      end
   end

   assign ss_in = (ss_ff + J_RND) >>> FRAC_BITS;
   assign sc_in = (sc_ff + J_RND) >>> FRAC_BITS;
   assign cs_in = (cs_ff + J_RND) >>> FRAC_BITS;
   assign cc_in = (cc_ff + J_RND) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (enable) begin
         j_ff[0][0] <= J_W'(c1_ff);
         j_ff[0][1] <= '0;
         j_ff[0][2] <= J_W'(s1_ff);
         j_ff[1][0] <= J_W'(ss_in);
         j_ff[1][1] <= J_W'(c0_ff);
         j_ff[1][2] <= -J_W'(sc_in);
         j_ff[2][0] <= -J_W'(cs_in);
         j_ff[2][1] <= J_W'(s0_ff);
         j_ff[2][2] <= J_W'(cc_in);
      end
   end

   assign out_valid = valid_b_ff;
   assign j_out     = j_ff;

endmodule

>>> design/ujt_matmul.sv
// ----------------------------------------------------------------------------
// ujt_matmul
// Fixed rotation times joint rotation: a stage of 27 products, then a stage
// of three-term sums with rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module ujt_matmul
   import ujt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  j_type            j_in [3][3],
   input  logic [ROW_W-1:0] rot_row [3],
   output logic             out_valid,
   output entry_type        m_out [3][3]
);

   logic                   valid_a_ff;
   logic                   valid_b_ff;
   logic signed [MP_W-1:0] prod_ff [3][3][3];
   entry_type              m_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         logic signed [ACC_W-1:0] acc_in;
         logic signed [ACC_W-1:0] rnd_in;
         entry_type               sat_in;

         for (genvar k = 0; k < 3; k++) begin : g_term
            always_ff @(posedge clock) begin
               if (enable) begin
                  prod_ff[r][k][c] <= MP_W'(signed'(rot_row[r][ROT_W*k +: ROT_W]))
                                    * MP_W'(j_in[k][c]);
               end
            end
         end

         assign acc_in = ACC_W'(prod_ff[r][0][c]) + ACC_W'(prod_ff[r][1][c])
                       + ACC_W'(prod_ff[r][2][c]);
         assign rnd_in = (acc_in + M_RND) >>> ROT_FRAC;

         always_comb begin
            if (rnd_in > M_HI) begin
               sat_in = ENTRY_WIDTH'(M_HI);
            end else if (rnd_in < M_LO) begin
               sat_in = ENTRY_WIDTH'(M_LO);
            end else begin
               sat_in = ENTRY_WIDTH'(rnd_in);
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               m_ff[r][c] <= sat_in;
            end
         end
      end
   end

   assign out_valid = valid_b_ff;
   assign m_out     = m_ff;

endmodule

>>> design/universal_joint_transform.sv
// throughput: one beat per cycle while no response is held back, set by the 30-stage cordic rotation pipeline
// the whole pipeline advances together and holds while a response is not taken
// reset (synchronous) clears all valid bits and loads the identity rotation
// and a zero translation into the configuration registers
// ----------------------------------------------------------------------------
// universal_joint_transform
// Two-axis joint orientation: sine/cosine of both angles, joint rotation and
// product with the configured fixed rotation; fixed translation passed along.
// ----------------------------------------------------------------------------
module universal_joint_transform
   import ujt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ANGLE_WIDTH-1:0] req_angle_first,
   input  logic [ANGLE_WIDTH-1:0] req_angle_second,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output entry_type              rsp_m00,
   output entry_type              rsp_m01,
   output entry_type              rsp_m02,
   output entry_type              rsp_m10,
   output entry_type              rsp_m11,
   output entry_type              rsp_m12,
   output entry_type              rsp_m20,
   output entry_type              rsp_m21,
   output entry_type              rsp_m22,
   output logic signed [POS_W-1:0] rsp_out_pos_x,
   output logic signed [POS_W-1:0] rsp_out_pos_y,
   output logic signed [POS_W-1:0] rsp_out_pos_z,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic             enable;
   logic [ROW_W-1:0] rot_row_ff [3];
   logic [POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [ANGLE_WIDTH-1:0] angle [2];
   logic             cordic_valid;
   cs_type           cos_w [2];
   cs_type           sin_w [2];
   logic             joint_valid;
   j_type            j_w [3][3];
   entry_type        m_w [3][3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0] <= ROW0_RESET;
         rot_row_ff[1] <= ROW1_RESET;
         rot_row_ff[2] <= ROW2_RESET;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         pos_z_ff      <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROT_ROW0: rot_row_ff[0] <= csr_wdata;
            REG_ROT_ROW1: rot_row_ff[1] <= csr_wdata;
            REG_ROT_ROW2: rot_row_ff[2] <= csr_wdata;
            REG_POS_X:    pos_x_ff      <= csr_wdata[POS_W-1:0];
            REG_POS_Y:    pos_y_ff      <= csr_wdata[POS_W-1:0];
            REG_POS_Z:    pos_z_ff      <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output register is free or being emptied
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign angle[0]  = req_angle_first;
   assign angle[1]  = req_angle_second;

   ujt_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .angle     (angle),
      .out_valid (cordic_valid),
      .cos_out   (cos_w),
      .sin_out   (sin_w)
   );

   ujt_joint u_joint (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (cordic_valid),
      .cos_in    (cos_w),
      .sin_in    (sin_w),
      .out_valid (joint_valid),
      .j_out     (j_w)
   );

   ujt_matmul u_matmul (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (joint_valid),
      .j_in      (j_w),
      .rot_row   (rot_row_ff),
      .out_valid (rsp_valid),
      .m_out     (m_w)
   );

   assign rsp_m00 = m_w[0][0];
   assign rsp_m01 = m_w[0][1];
   assign rsp_m02 = m_w[0][2];
   assign rsp_m10 = m_w[1][0];
   assign rsp_m11 = m_w[1][1];
   assign rsp_m12 = m_w[1][2];
   assign rsp_m20 = m_w[2][0];
   assign rsp_m21 = m_w[2][1];
   assign rsp_m22 = m_w[2][2];

   // the user keeps configuration static while beats are in flight; not enforced
   assign rsp_out_pos_x = signed'(pos_x_ff);
   assign rsp_out_pos_y = signed'(pos_y_ff);
   assign rsp_out_pos_z = signed'(pos_z_ff);

endmodule

>>> design/ujt_checker.sv
// ----------------------------------------------------------------------------
// ujt_checker
// Port-level checks on the universal joint transform, bound to the top level.
// ----------------------------------------------------------------------------
module ujt_checker
   import ujt_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input logic      csr_ready,
   input entry_type rsp_m00,
   input entry_type rsp_m22
);

   a_rst_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_m00) && $stable(rsp_m22)))
      else $error("stalled response beat changed");

   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind universal_joint_transform ujt_checker u_ujt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .csr_ready (csr_ready),
   .rsp_m00   (rsp_m00),
   .rsp_m22   (rsp_m22)
);
